/* hw/rtl/qdr_pkg.sv */
// ----------------------------------------------------------------------------
// qdr_pkg
// Types, constants and the transition table shared by the decoder modules.
// ----------------------------------------------------------------------------
package qdr_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_MIN_GAP  = 2'd0,
        CFG_MAX_GAP  = 2'd1,
        CFG_IDLE_LIM = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_index;

    // Register reset values
    localparam logic [19:0] MIN_GAP_RESET  = 20'd100;
    localparam logic [31:0] MAX_GAP_RESET  = 32'd1000000;
    localparam logic [31:0] IDLE_LIM_RESET = 32'd200000;

    // Kind of phase transition
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2,
        STEP_SKIP = 2'd3
    } t_step;

    // Transition table, index {previous pair, current pair}; forward 0-2-3-1-0 counts up
    localparam t_step STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_SKIP,
        STEP_UP,   STEP_NONE, STEP_SKIP, STEP_DOWN,
        STEP_DOWN, STEP_SKIP, STEP_NONE, STEP_UP,
        STEP_SKIP, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    // Speed arithmetic: instant speed = INST_NUM / gap, 72 phase transitions per revolution
    localparam int          DIV_BITS   = 28;
    localparam logic [27:0] INST_NUM   = 28'd213333333;
    localparam logic [7:0]  FILT_OLD   = 8'd179;
    localparam logic [7:0]  FILT_NEW   = 8'd77;
    localparam logic [7:0]  DECAY_MULT = 8'd243;
    localparam logic [21:0] SPEED_MAX  = 22'h3FFFFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [19:0] min_gap;
        logic [31:0] max_gap;
        logic [31:0] idle_lim;
    } t_cfg;

    // Classified sample handed from front to back
    typedef struct packed {
        logic [31:0] position_count;
        logic [30:0] detent_count;
        logic [31:0] missed_edges;
        logic        edge_seen;
        logic        refresh;
        logic        decay;
        logic [31:0] gap;
    } t_item;

    typedef struct packed {
        logic [31:0] position_count;
        logic [30:0] detent_count;
        logic [21:0] speed_rpm_q8;
        logic [31:0] missed_edges;
        logic        edge_seen;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic busy;
    } t_back_status;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_DIV   = 3'd1,
        BK_MUL   = 3'd2,
        BK_SUM   = 3'd3,
        BK_DECAY = 3'd4
    } t_back_state;

endpackage

/* hw/rtl/qdr_front.sv */
// ----------------------------------------------------------------------------
// qdr_front
// Accepts samples, decodes the phase step, keeps position, miss count and
// last edge time, and classifies each sample for the speed back end.
// ----------------------------------------------------------------------------
module qdr_front
    import qdr_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_phase_a,
    input  logic          i_phase_b,
    input  logic [31:0]   i_time_us,
    input  t_queue_status i_queue,
    output logic          o_push,
    output t_item         o_item
);

    logic [1:0]            r_prev, n_prev;
    logic                  r_primed, n_primed;
    logic [COUNT_BITS-1:0] r_pos, n_pos;
    logic [31:0]           r_last, n_last;
    logic [31:0]           r_miss, n_miss;

    logic [1:0]         w_curr;
    t_step              w_step;
    logic [31:0]        w_gap;
    logic               w_edge;
    logic               w_refresh;
    logic               w_decay;
    logic signed [63:0] w_pos_ext;
    logic [31:0]        w_det_sum;

    assign o_ready = !i_queue.full;
    assign o_push  = i_valid && !i_queue.full;

    assign w_curr = {i_phase_a, i_phase_b};
    assign w_step = STEP_TABLE[{r_prev, w_curr}];
    assign w_gap  = i_time_us - r_last;

    // Decode the step and update counters
    always_comb begin
        n_prev    = w_curr;
        n_primed  = 1'b1;
        n_pos     = r_pos;
        n_last    = r_last;
        n_miss    = r_miss;
        w_edge    = 1'b0;
        w_refresh = 1'b0;
        w_decay   = 1'b0;
        if (r_primed) begin
            unique case (w_step)
                STEP_SKIP: begin
                    n_miss = r_miss + 32'd1;
                end
                STEP_UP: begin
                    n_pos  = r_pos + COUNT_BITS'(1);
                    w_edge = 1'b1;
                end
                STEP_DOWN: begin
                    n_pos  = r_pos - COUNT_BITS'(1);
                    w_edge = 1'b1;
                end
                STEP_NONE: begin
                end
            endcase
            if (w_edge) begin
                n_last = i_time_us;
            end
            w_refresh = w_edge && (w_gap > {12'd0, i_cfg.min_gap})
                        && (w_gap < i_cfg.max_gap) && (w_gap != 32'd0);
            // an edge resets the idle time to zero, so only idle samples decay
            w_decay   = !w_edge && (w_gap > i_cfg.idle_lim);
        end
    end

    // Detent count: position / 2 truncated toward zero
    assign w_pos_ext = 64'(signed'(n_pos));
    assign w_det_sum = w_pos_ext[31:0] + 32'(w_pos_ext[63]);

    always_comb begin
        o_item.position_count = w_pos_ext[31:0];
        o_item.detent_count   = w_det_sum[31:1];
        o_item.missed_edges   = n_miss;
        o_item.edge_seen      = w_edge;
        o_item.refresh        = w_refresh;
        o_item.decay          = w_decay;
        o_item.gap            = w_gap;
    end

    // Hold decoder state, advance on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 2'd0;
            r_primed <= 1'b0;
            r_pos    <= '0;
            r_last   <= 32'd0;
            r_miss   <= 32'd0;
        end else if (o_push) begin
            r_prev   <= n_prev;
            r_primed <= n_primed;
            r_pos    <= n_pos;
            r_last   <= n_last;
            r_miss   <= n_miss;
        end
    end

endmodule

/* hw/rtl/qdr_queue.sv */
// ----------------------------------------------------------------------------
// qdr_queue
// Short first-in first-out queue of classified samples between the front
// and the back end.
// ----------------------------------------------------------------------------
module qdr_queue
    import qdr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output t_queue_status o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_item          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/qdr_back.sv */
// ----------------------------------------------------------------------------
// qdr_back
// Speed back end: radix-2 divide for the instant speed, low-pass filter,
// idle decay, and the output register.
// ----------------------------------------------------------------------------
module qdr_back
    import qdr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_item         i_item,
    input  logic          i_item_valid,
    output logic          o_pop,
    output t_result       o_result,
    output logic          o_valid,
    input  logic          i_ready,
    output t_back_status  o_status
);

    localparam int CNT_W = $clog2(DIV_BITS);

    t_back_state        r_state, n_state;
    t_item              r_item;
    logic [DIV_BITS-1:0] r_quo;
    logic [31:0]        r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic [29:0]        r_p_old;
    logic [34:0]        r_p_new;
    logic [21:0]        r_speed;
    logic               r_out_valid;
    t_result            r_result;

    logic [32:0]        w_rem_sh;
    logic [32:0]        w_rem_diff;
    logic               w_qbit;
    logic [31:0]        w_rem_next;
    logic [34:0]        w_sum;
    logic [26:0]        w_sum_sh;
    logic [21:0]        w_speed_sat;
    logic [29:0]        w_dec_prod;
    logic [21:0]        w_speed_out;

    // Divide step: shift in one dividend bit, subtract when it fits
    assign w_rem_sh   = {r_rem, r_quo[DIV_BITS-1]};
    assign w_rem_diff = w_rem_sh - {1'b0, r_item.gap};
    assign w_qbit     = (w_rem_sh >= {1'b0, r_item.gap});
    assign w_rem_next = w_qbit ? w_rem_diff[31:0] : w_rem_sh[31:0];

    // Filter sum with saturation
    assign w_sum       = 35'(r_p_old) + r_p_new;
    assign w_sum_sh    = w_sum[34:8];
    assign w_speed_sat = (w_sum_sh[26:22] != 5'd0) ? SPEED_MAX : w_sum_sh[21:0];

    // Idle decay
    assign w_dec_prod  = 30'(DECAY_MULT) * 30'(r_speed);
    assign w_speed_out = r_item.decay ? w_dec_prod[29:8] : r_speed;

    assign o_valid         = r_out_valid;
    assign o_result        = r_result;
    assign o_status.busy   = (r_state != BK_IDLE);

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and queue pop
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_item_valid && !r_out_valid) begin
                    o_pop   = 1'b1;
                    n_state = i_item.refresh ? BK_DIV : BK_DECAY;
                end
            end
            BK_DIV: begin
                if (r_cnt == '0) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_state = BK_SUM;
            end
            BK_SUM: begin
                n_state = BK_DECAY;
            end
            BK_DECAY: begin
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Datapath: latch item, iterate divider, form filter products, load result
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
            r_quo  <= INST_NUM;
            r_rem  <= 32'd0;
            r_cnt  <= CNT_W'(DIV_BITS - 1);
        end
        if (r_state == BK_DIV) begin
            r_quo <= {r_quo[DIV_BITS-2:0], w_qbit};
            r_rem <= w_rem_next;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (r_state == BK_MUL) begin
            r_p_old <= 30'(FILT_OLD) * 30'(r_speed);
            r_p_new <= 35'(FILT_NEW) * 35'(r_quo);
        end
        if (r_state == BK_DECAY) begin
            r_result.position_count <= r_item.position_count;
            r_result.detent_count   <= r_item.detent_count;
            r_result.speed_rpm_q8   <= w_speed_out;
            r_result.missed_edges   <= r_item.missed_edges;
            r_result.edge_seen      <= r_item.edge_seen;
        end
    end

    // Filtered speed and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= 22'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == BK_SUM) begin
                r_speed <= w_speed_sat;
            end else if (r_state == BK_DECAY) begin
                r_speed <= w_speed_out;
            end
            if (r_state == BK_DECAY) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/quadrature_decoder_with_rpm_top.sv */
// ----------------------------------------------------------------------------
// quadrature_decoder_with_rpm_top
// 4x quadrature decoder with position, miss count and filtered rpm estimate.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one poll sample per request: phase A, phase B and a
//   free-running microsecond timestamp. Master stream returns one result per
//   sample: position, detent count, speed in rpm (Q.8), miss count, and in
//   tuser a flag marking a valid edge. The first sample after reset only
//   primes the previous phase pair.
//   Configuration writes (min gap, max gap, idle limit) go in while idle.
// Timing:
//   The front decodes a sample in the cycle it is accepted and parks it in
//   a two-entry queue. The back passes a sample without speed refresh
//   through its decay state only, and a refreshed edge through the 28-step
//   radix-2 divider of the instant speed, then the multiply, sum and decay
//   states. It takes no new sample from the queue until its output
//   register has drained, so it finishes each sample before the next.
// Reset and stall:
//   Reset clears position, counters, speed and the queue and loads the
//   register defaults. A stalled master holds its result; the queue keeps
//   taking samples until full, then tready drops.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_rpm_top
    import qdr_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    // sample stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [39:0]  i_s_axis_tdata,  // phase_a, phase_b, time_us[31:0], zero pad
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [119:0] o_m_axis_tdata,  // position_count[31:0], detent_count[30:0],
                                          // speed_rpm_q8[21:0], missed_edges[31:0], zero pad
    output logic [0:0]   o_m_axis_tuser   // edge_seen
);

    t_cfg          r_cfg;
    t_item         w_front_item;
    logic          w_push;
    t_item         w_queue_item;
    t_queue_status w_queue;
    logic          w_pop;
    t_result       w_result;
    t_back_status  w_back;

    // Hold configuration registers, drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gap  <= MIN_GAP_RESET;
            r_cfg.max_gap  <= MAX_GAP_RESET;
            r_cfg.idle_lim <= IDLE_LIM_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIN_GAP:  r_cfg.min_gap  <= i_cfg_data[19:0];
                CFG_MAX_GAP:  r_cfg.max_gap  <= i_cfg_data;
                CFG_IDLE_LIM: r_cfg.idle_lim <= i_cfg_data;
                CFG_UNUSED: begin
                end
            endcase
        end
    end

    qdr_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_phase_a (i_s_axis_tdata[0]),
        .i_phase_b (i_s_axis_tdata[1]),
        .i_time_us (i_s_axis_tdata[33:2]),
        .i_queue   (w_queue),
        .o_push    (w_push),
        .o_item    (w_front_item)
    );

    qdr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_queue_item),
        .o_status (w_queue)
    );

    qdr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_queue_item),
        .i_item_valid (!w_queue.empty),
        .o_pop        (w_pop),
        .o_result     (w_result),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_status     (w_back)
    );

    // Pack result fields
    assign o_m_axis_tdata = {3'd0, w_result.missed_edges, w_result.speed_rpm_q8,
                             w_result.detent_count, w_result.position_count};
    assign o_m_axis_tuser = w_result.edge_seen;

    // Queue is never full and empty at once
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_queue.full && w_queue.empty))
        else $error("queue reports full and empty together");

    // An accepted request always leaves the queue non-empty
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !w_queue.empty)
        else $error("accepted sample did not reach the queue");

    // Back end only runs while the output register is free
    a_back_vs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_back.busy && o_m_axis_tvalid))
        else $error("back end busy while a result waits");

    // A new result only appears at the end of a back-end sequence
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_back.busy))
        else $error("result appeared without back-end work");

endmodule
